// File: rtl/core/esp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_BIRTH = 1'b1;

	typedef struct packed {
		logic        func;
		logic [15:0] time_step;
		logic [23:0] life_span;
		logic [15:0] birth_age;
	} esp_req_t;

	typedef struct packed {
		logic        granted;
		logic [11:0] slot_index;
		logic [31:0] birth_time;
		logic [12:0] live_total;
		logic [31:0] drop_total;
	} esp_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_DRAIN,
		ST_BIRTH_RD,
		ST_BIRTH_WR,
		ST_DONE
	} esp_state_t;

	typedef struct packed {
		logic cap;
		logic clr_step;
		logic tick_zero;
		logic tick_start;
		logic scan_step;
		logic birth_rd;
		logic birth_wr;
		logic drop;
		logic rsp_load;
	} esp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_birth;
		logic size_zero;
		logic scan_last;
		logic birth_ok;
	} esp_sts_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? TIME_MAX : s[31:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/esp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module esp_ctrl
	import esp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output esp_cmd_t      cmd,
	input  wire esp_sts_t sts
);

	esp_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rsp_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = sts.is_birth ? ST_BIRTH_RD : ST_TICK;
				end
			end
			ST_TICK: begin
				if (sts.size_zero) begin
					cmd.tick_zero = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.tick_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last)
					state_d = ST_DRAIN;
			end
			// last read beat is folded into the counts here
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_BIRTH_RD: begin
				if (sts.birth_ok) begin
					cmd.birth_rd = 1'b1;
					state_d      = ST_BIRTH_WR;
				end else begin
					cmd.drop = 1'b1;
					state_d  = ST_DONE;
				end
			end
			ST_BIRTH_WR: begin
				cmd.birth_wr = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/esp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module esp_datapath
	import esp_pkg::*;
#(
	parameter int POOL_SLOTS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire esp_req_t    req,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata,
	input  wire esp_cmd_t    cmd,
	output esp_sts_t         sts,
	output esp_rsp_t         rsp
);

	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam int CNT_W = $clog2(POOL_SLOTS + 1);

	logic [31:0]      expiry_mem [POOL_SLOTS];
	logic [IDX_W-1:0] free_mem   [POOL_SLOTS];

	esp_req_t         req_q;
	esp_rsp_t         rsp_q;
	logic [CNT_W-1:0] size_q;
	logic [31:0]      clock_q;
	logic [31:0]      drop_q;
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] free_count_q;
	logic [CNT_W-1:0] next_free_q;
	logic [IDX_W-1:0] idx_q;
	logic             gnt_q;

	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      rd_data_s1;
	logic [IDX_W-1:0] slot_s1;
	logic [31:0]      birth_s1;
	logic [31:0]      life_s1;

	logic             exp_we;
	logic [IDX_W-1:0] exp_waddr;
	logic [31:0]      exp_wdata;
	logic             slot_dead;

	assign sts.clr_last  = (idx_q == IDX_W'(POOL_SLOTS - 1));
	assign sts.is_birth  = (req.func == FUNC_BIRTH);
	assign sts.size_zero = (size_q == '0);
	assign sts.scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == size_q);
	assign sts.birth_ok  = !sts.size_zero && (next_free_q < free_count_q);

	assign slot_dead = vld_s1 && !(rd_data_s1 > clock_q);

	always_comb begin
		exp_we    = cmd.clr_step || cmd.birth_wr;
		exp_waddr = cmd.clr_step ? idx_q : slot_s1;
		exp_wdata = cmd.clr_step ? 32'd0 : sat_add(birth_s1, life_s1);
	end

	always_ff @(posedge clk) begin
		if (exp_we)
			expiry_mem[exp_waddr] <= exp_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step)
			rd_data_s1 <= expiry_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (slot_dead)
			free_mem[free_count_q[IDX_W-1:0]] <= idx_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.birth_rd)
			slot_s1 <= free_mem[next_free_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.cap)
			req_q <= req;
		if (cmd.scan_step)
			idx_s1 <= idx_q;
		if (cmd.birth_rd) begin
			birth_s1 <= (clock_q >= 32'(req_q.birth_age)) ?
				clock_q - 32'(req_q.birth_age) : 32'd0;
			life_s1  <= (req_q.life_span == '0) ? 32'd1 : 32'(req_q.life_span);
		end
		if (cmd.rsp_load) begin
			rsp_q.granted    <= gnt_q;
			rsp_q.slot_index <= gnt_q ? 12'(32'(slot_s1)) : 12'd0;
			rsp_q.birth_time <= gnt_q ? birth_s1 : 32'd0;
			rsp_q.live_total <= 13'(32'(live_q));
			rsp_q.drop_total <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= '0;
			clock_q      <= '0;
			drop_q       <= '0;
			live_q       <= '0;
			free_count_q <= '0;
			next_free_q  <= '0;
			idx_q        <= '0;
			gnt_q        <= 1'b0;
			vld_s1       <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_step;
			if (cfg_we)
				size_q <= (32'(cfg_wdata) > 32'(POOL_SLOTS)) ?
					CNT_W'(POOL_SLOTS) : CNT_W'(cfg_wdata);
			if (cmd.cap)
				gnt_q <= 1'b0;
			if (cmd.clr_step || cmd.scan_step)
				idx_q <= idx_q + IDX_W'(1);
			if (cmd.tick_zero)
				live_q <= '0;
			if (cmd.tick_start) begin
				clock_q      <= sat_add(clock_q, 32'(req_q.time_step));
				live_q       <= '0;
				free_count_q <= '0;
				next_free_q  <= '0;
				idx_q        <= '0;
			end
			if (vld_s1) begin
				if (slot_dead)
					free_count_q <= free_count_q + CNT_W'(1);
				else
					live_q <= live_q + CNT_W'(1);
			end
			if (cmd.birth_rd)
				next_free_q <= next_free_q + CNT_W'(1);
			if (cmd.birth_wr) begin
				live_q <= live_q + CNT_W'(1);
				gnt_q  <= 1'b1;
			end
			if (cmd.drop && drop_q != TIME_MAX)
				drop_q <= drop_q + 32'd1;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// File: rtl/core/expiring_slot_pool.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Handshake              Payload      Direction
// req        req_valid / req_stall  esp_req_t    in
// rsp        rsp_valid / rsp_stall  esp_rsp_t    out
// cfg        cfg_we                 cfg_wdata    in (pool size, write only)
//
// Birth beat: a free list read, then an expiry write; a refused birth does neither.
// Tick beat: one expiry memory read per slot; a disabled pool skips the scan.
// After reset a clearing pass zeroes the expiry memory with req_stall high.
// The result register lets the next beat in while rsp is stalled.

module expiring_slot_pool
	import esp_pkg::*;
#(
	parameter int POOL_SLOTS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire esp_req_t    req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output esp_rsp_t         rsp,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata
);

	esp_cmd_t cmd;
	esp_sts_t sts;

	esp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	esp_datapath #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.tick_zero, cmd.tick_start, cmd.scan_step,
			cmd.birth_rd, cmd.birth_wr, cmd.drop}))
		else $error("more than one datapath command at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> !(rsp_valid && rsp_stall))
		else $error("result register loaded while a stalled beat waits");

	a_birth_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.birth_wr |-> $past(cmd.birth_rd))
		else $error("expiry write without a free list read");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !(cmd.scan_step || cmd.clr_step || cmd.birth_wr))
		else $error("beat accepted while the datapath is busy");

endmodule

`default_nettype wire
